// File: rtl/hfna_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfna_pkg
// Shared widths, register indexes, cell and command types, and the
// reciprocal table used by the neighbor mean.
// ----------------------------------------------------------------------------
package hfna_pkg;

  localparam int HFNA_MAX_WIDTH = 1024;

  localparam int CH_W          = 8;
  localparam int IMG_WIDTH_W   = 11;
  localparam int IMG_HEIGHT_W  = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int NUM_NEIGHBORS = 8;
  localparam int SUM_W         = 11;
  localparam int NCNT_W        = 4;
  localparam int RECIP_W       = 15;
  localparam int RECIP_SHIFT   = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [IMG_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [IMG_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

  typedef struct packed {
    logic            hole;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } hfna_cell_t;

  localparam hfna_cell_t HOLE_CELL = '{hole: 1'b1, blue: '0, green: '0, red: '0};

  // one line-buffer entry: the two rows above the incoming one
  typedef struct packed {
    hfna_cell_t older;
    hfna_cell_t newer;
  } hfna_pair_t;

  typedef struct packed {
    logic       wr_row;
    logic       top_vld;
    logic       mid_vld;
    logic       first_col;
    logic       emit;
    logic       frame_end;
    hfna_cell_t bottom;
  } hfna_cmd_t;

  // ceil(2^14 / n), exact floor division for numerators below 2048
  function automatic logic [RECIP_W-1:0] hfna_recip(input logic [NCNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      4'd1:    r = 15'd16384;
      4'd2:    r = 15'd8192;
      4'd3:    r = 15'd5462;
      4'd4:    r = 15'd4096;
      4'd5:    r = 15'd3277;
      4'd6:    r = 15'd2731;
      4'd7:    r = 15'd2341;
      4'd8:    r = 15'd2048;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/hfna_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfna_in_if
// Pixel input channel: valid/ready with one raster pixel or a drain beat.
// ----------------------------------------------------------------------------
interface hfna_in_if;
  import hfna_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  logic            is_hole;
  logic            drain;

  modport source (
    output valid, red_in, green_in, blue_in, is_hole, drain,
    input  ready
  );

  modport sink (
    input  valid, red_in, green_in, blue_in, is_hole, drain,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/hfna_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfna_out_if
// Result channel: valid/ready with one finished pixel and its flags.
// ----------------------------------------------------------------------------
interface hfna_out_if;
  import hfna_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            was_filled;
  logic            left_unfilled;
  logic            frame_end;

  modport source (
    output valid, red_out, green_out, blue_out, was_filled, left_unfilled, frame_end,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out, was_filled, left_unfilled, frame_end,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/hfna_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfna_front
// Accepts pixel and drain beats, tracks raster position and the flush count,
// and turns each beat into a line-buffer command for the back end.
// ----------------------------------------------------------------------------
module hfna_front #(
  parameter int MAX_WIDTH = hfna_pkg::HFNA_MAX_WIDTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [hfna_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [hfna_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  hfna_in_if.sink                               pix_i,
  input  wire logic                             q_full_i,
  output logic                                  q_push_o,
  output logic [$clog2(MAX_WIDTH)-1:0]          q_addr_o,
  output hfna_pkg::hfna_cmd_t                   q_cmd_o
);
  import hfna_pkg::*;

  localparam int AddrW = $clog2(MAX_WIDTH);
  localparam int CntW  = $clog2(MAX_WIDTH + 2);

  logic [IMG_WIDTH_W-1:0]  img_w_q;
  logic [IMG_HEIGHT_W-1:0] img_h_q;
  logic [AddrW-1:0]        col_q, col_d;
  logic [IMG_HEIGHT_W-1:0] row_q, row_d;
  logic [CntW-1:0]         pend_q, pend_d;

  logic [CntW-1:0]         eff_w;
  logic [IMG_HEIGHT_W-1:0] eff_h;
  logic [AddrW-1:0]        c;
  logic [CntW-1:0]         k;
  logic [IMG_HEIGHT_W:0]   row_inc;
  logic                    h_ge2, r_ge1, r_ge2, c_zero;
  logic                    accept, cfg_hit;

  always_comb begin
    if (img_w_q == '0) begin
      eff_w = CntW'(1);
    end else if (int'(img_w_q) > MAX_WIDTH) begin
      eff_w = CntW'(MAX_WIDTH);
    end else begin
      eff_w = CntW'(img_w_q);
    end
  end

  assign eff_h   = (img_h_q == '0) ? IMG_HEIGHT_W'(1) : img_h_q;
  assign c       = (CntW'(col_q) >= eff_w) ? '0 : col_q;
  assign k       = eff_w + CntW'(1) - pend_q;
  assign row_inc = {1'b0, row_q} + (IMG_HEIGHT_W + 1)'(1);
  assign h_ge2   = eff_h > IMG_HEIGHT_W'(1);
  assign r_ge1   = row_q != '0;
  assign r_ge2   = row_q > IMG_HEIGHT_W'(1);
  assign c_zero  = c == '0;

  assign pix_i.ready = !q_full_i;
  assign accept      = pix_i.valid && pix_i.ready;
  assign cfg_hit     = cfg_we_i &&
                       (cfg_idx_i == CFG_IMAGE_WIDTH || cfg_idx_i == CFG_IMAGE_HEIGHT);

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    pend_d   = pend_q;
    q_push_o = 1'b0;
    q_addr_o = '0;
    q_cmd_o  = '0;
    q_cmd_o.bottom = HOLE_CELL;
    if (accept) begin
      if (pix_i.drain) begin
        // a drain with nothing owed is swallowed
        if (pend_q != '0) begin
          pend_d   = pend_q - CntW'(1);
          q_push_o = 1'b1;
          if (k >= eff_w) begin
            // closing column past the right edge
            q_cmd_o.first_col = 1'b1;
            q_cmd_o.emit      = 1'b1;
            q_cmd_o.frame_end = 1'b1;
          end else begin
            q_addr_o          = k[AddrW-1:0];
            q_cmd_o.first_col = k == '0;
            q_cmd_o.emit      = (k != '0) || h_ge2;
            q_cmd_o.top_vld   = h_ge2;
            q_cmd_o.mid_vld   = 1'b1;
          end
        end
      end else begin
        pend_d            = '0;
        q_push_o          = 1'b1;
        q_addr_o          = c;
        q_cmd_o.wr_row    = 1'b1;
        q_cmd_o.top_vld   = r_ge2;
        q_cmd_o.mid_vld   = r_ge1;
        q_cmd_o.first_col = c_zero;
        q_cmd_o.emit      = c_zero ? r_ge2 : r_ge1;
        q_cmd_o.bottom    = '{hole: pix_i.is_hole, blue: pix_i.blue_in,
                              green: pix_i.green_in, red: pix_i.red_in};
        if (CntW'(c) + CntW'(1) >= eff_w) begin
          col_d = '0;
          if (row_inc >= {1'b0, eff_h}) begin
            row_d  = '0;
            pend_d = eff_w + CntW'(1);
          end else begin
            row_d = row_inc[IMG_HEIGHT_W-1:0];
          end
        end else begin
          col_d = c + AddrW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMAGE_WIDTH_RESET;
      img_h_q <= IMAGE_HEIGHT_RESET;
      col_q   <= '0;
      row_q   <= '0;
      pend_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_IMAGE_WIDTH) begin
        img_w_q <= cfg_wdata_i[IMG_WIDTH_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_IMAGE_HEIGHT) begin
        img_h_q <= cfg_wdata_i[IMG_HEIGHT_W-1:0];
      end
      // a register write restarts the frame
      if (cfg_hit) begin
        col_q  <= '0;
        row_q  <= '0;
        pend_q <= '0;
      end else begin
        col_q  <= col_d;
        row_q  <= row_d;
        pend_q <= pend_d;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/hfna_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfna_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hfna_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hfna_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);
  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/hfna_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfna_back
// Executes line-buffer commands: row-pair memory, 3x3 window, masked
// neighbor sum and rounded mean, and the output register.
// ----------------------------------------------------------------------------
module hfna_back #(
  parameter int MAX_WIDTH = hfna_pkg::HFNA_MAX_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_empty_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] q_addr_i,
  input  wire hfna_pkg::hfna_cmd_t          q_cmd_i,
  output logic                              q_pop_o,
  hfna_out_if.source                        res_o
);
  import hfna_pkg::*;

  localparam int AddrW = $clog2(MAX_WIDTH);
  localparam int ProdW = SUM_W + RECIP_W;

  logic advance;

  // row-pair memory, no reset
  hfna_pair_t row_mem_q [MAX_WIDTH];

  // issue / line-buffer stage
  logic             b_vld_q;
  hfna_cmd_t        b_cmd_q;
  logic [AddrW-1:0] b_addr_q;
  hfna_pair_t       rd_pair_q;
  logic             fwd_q;
  hfna_pair_t       fwd_pair_q;
  hfna_pair_t       cur_pair, wr_pair;
  hfna_cell_t       new_col   [3];
  hfna_cell_t       right_col [3];
  hfna_cell_t       win_mid_q   [3];
  hfna_cell_t       win_right_q [3];

  // window snapshot stage
  logic       c_vld_q;
  hfna_cell_t c_nb_q [NUM_NEIGHBORS];
  hfna_cell_t c_ctr_q;
  logic       c_fe_q;

  // sum stage
  logic              d_vld_q;
  logic [SUM_W-1:0]  d_sum_r_q, d_sum_g_q, d_sum_b_q;
  logic [NCNT_W-1:0] d_cnt_q;
  hfna_cell_t        d_ctr_q;
  logic              d_fe_q;
  logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
  logic [NCNT_W-1:0] cnt;

  // mean and output
  logic [SUM_W-1:0]   half;
  logic [RECIP_W-1:0] recip;
  logic [ProdW-1:0]   prod_r, prod_g, prod_b;
  logic               out_vld_q;
  hfna_cell_t         out_cell_q, out_cell_d;
  logic               out_fill_q, out_fill_d;
  logic               out_unf_q, out_unf_d;
  logic               out_fe_q;

  assign advance = !out_vld_q || res_o.ready;
  assign q_pop_o = advance && !q_empty_i;

  // memory: write from the line-buffer stage, registered read on pop
  always_ff @(posedge clk_i) begin
    if (advance && b_vld_q && b_cmd_q.wr_row) begin
      row_mem_q[b_addr_q] <= wr_pair;
    end
    if (q_pop_o) begin
      rd_pair_q <= row_mem_q[q_addr_i];
    end
  end

  // write to the same entry on the pop edge reads stale data
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b_cmd_q    <= q_cmd_i;
      b_addr_q   <= q_addr_i;
      fwd_pair_q <= wr_pair;
    end
  end

  assign cur_pair = fwd_q ? fwd_pair_q : rd_pair_q;
  assign wr_pair  = '{older: cur_pair.newer, newer: b_cmd_q.bottom};

  always_comb begin
    new_col[0] = b_cmd_q.top_vld ? cur_pair.older : HOLE_CELL;
    new_col[1] = b_cmd_q.mid_vld ? cur_pair.newer : HOLE_CELL;
    new_col[2] = b_cmd_q.bottom;
    for (int i = 0; i < 3; i++) begin
      right_col[i] = b_cmd_q.first_col ? HOLE_CELL : new_col[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c_nb_q[0] <= win_mid_q[0];
      c_nb_q[1] <= win_mid_q[1];
      c_nb_q[2] <= win_mid_q[2];
      c_nb_q[3] <= win_right_q[0];
      c_nb_q[4] <= win_right_q[2];
      c_nb_q[5] <= right_col[0];
      c_nb_q[6] <= right_col[1];
      c_nb_q[7] <= right_col[2];
      c_ctr_q   <= win_right_q[1];
      c_fe_q    <= b_cmd_q.frame_end;
    end
  end

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    cnt   = '0;
    for (int i = 0; i < NUM_NEIGHBORS; i++) begin
      if (!c_nb_q[i].hole) begin
        sum_r = sum_r + SUM_W'(c_nb_q[i].red);
        sum_g = sum_g + SUM_W'(c_nb_q[i].green);
        sum_b = sum_b + SUM_W'(c_nb_q[i].blue);
        cnt   = cnt + NCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      d_sum_r_q <= sum_r;
      d_sum_g_q <= sum_g;
      d_sum_b_q <= sum_b;
      d_cnt_q   <= cnt;
      d_ctr_q   <= c_ctr_q;
      d_fe_q    <= c_fe_q;
    end
  end

  // round to nearest, ties up: (sum + n/2) * ceil(2^14/n) >> 14
  assign half   = SUM_W'(d_cnt_q >> 1);
  assign recip  = hfna_recip(d_cnt_q);
  assign prod_r = ProdW'(d_sum_r_q + half) * ProdW'(recip);
  assign prod_g = ProdW'(d_sum_g_q + half) * ProdW'(recip);
  assign prod_b = ProdW'(d_sum_b_q + half) * ProdW'(recip);

  always_comb begin
    out_cell_d = d_ctr_q;
    out_fill_d = 1'b0;
    out_unf_d  = 1'b0;
    if (d_ctr_q.hole) begin
      if (d_cnt_q == '0) begin
        out_unf_d = 1'b1;
      end else begin
        out_cell_d.red   = prod_r[RECIP_SHIFT +: CH_W];
        out_cell_d.green = prod_g[RECIP_SHIFT +: CH_W];
        out_cell_d.blue  = prod_b[RECIP_SHIFT +: CH_W];
        out_fill_d       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_cell_q <= out_cell_d;
      out_fill_q <= out_fill_d;
      out_unf_q  <= out_unf_d;
      out_fe_q   <= d_fe_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      fwd_q     <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win_mid_q[i]   <= '0;
        win_right_q[i] <= '0;
      end
    end else begin
      if (q_pop_o) begin
        fwd_q <= b_vld_q && b_cmd_q.wr_row && (b_addr_q == q_addr_i);
      end
      if (advance) begin
        b_vld_q   <= q_pop_o;
        c_vld_q   <= b_vld_q && b_cmd_q.emit;
        d_vld_q   <= c_vld_q;
        out_vld_q <= d_vld_q;
        if (b_vld_q) begin
          // column zero restarts the window with holes on the left
          for (int i = 0; i < 3; i++) begin
            win_mid_q[i]   <= b_cmd_q.first_col ? HOLE_CELL : win_right_q[i];
            win_right_q[i] <= new_col[i];
          end
        end
      end
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.red_out       = out_cell_q.red;
  assign res_o.green_out     = out_cell_q.green;
  assign res_o.blue_out      = out_cell_q.blue;
  assign res_o.was_filled    = out_fill_q;
  assign res_o.left_unfilled = out_unf_q;
  assign res_o.frame_end     = out_fe_q;

endmodule
`default_nettype wire

// File: rtl/hole_fill_neighbour_average_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hole_fill_neighbour_average_core
// Streaming 3x3 masked-mean hole filling for an RGB raster.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i takes one beat per cycle while ready is high: a pixel in raster
//   order with its hole mark, or a drain beat. After the last pixel of a
//   frame, width + 1 drain beats flush the remaining results; extra drains
//   are swallowed. res_o gives one finished pixel per beat, in raster order;
//   a pixel's result is completed by the pixel one line and one pixel later,
//   then passes the queue and the line-buffer, window, sum and output
//   registers. Throughput is one beat per cycle unless res_o stalls, set by
//   the row-pair memory that is read and written once per beat.
//   cfg_we_i writes image_width (index 0) or image_height (index 1) and
//   restarts the frame; write only while the block is idle.
//   When res_o stalls the output register holds, the back pipeline freezes,
//   and the four-entry command queue fills before pix_i drops ready.
//   Reset loads 640x480 and clears position and flush count at once; the
//   line memory is not cleared, since rows are marked valid by position.
// ----------------------------------------------------------------------------
module hole_fill_neighbour_average_core #(
  parameter int MAX_WIDTH = hfna_pkg::HFNA_MAX_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [hfna_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [hfna_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  hfna_in_if.sink                              pix_i,
  hfna_out_if.source                           res_o
);
  import hfna_pkg::*;

  localparam int AddrW = $clog2(MAX_WIDTH);
  localparam int QW    = AddrW + $bits(hfna_cmd_t);

  logic             push, full, pop, empty;
  logic [AddrW-1:0] push_addr, pop_addr;
  hfna_cmd_t        push_cmd, pop_cmd;
  logic [QW-1:0]    q_wdata, q_rdata;

  hfna_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_i),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_addr_o    (push_addr),
    .q_cmd_o     (push_cmd)
  );

  assign q_wdata = {push_addr, push_cmd};

  hfna_cmd_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .empty_o (empty)
  );

  assign pop_addr = q_rdata[QW-1 -: AddrW];
  assign pop_cmd  = q_rdata[$bits(hfna_cmd_t)-1:0];

  hfna_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (empty),
    .q_addr_i  (pop_addr),
    .q_cmd_i   (pop_cmd),
    .q_pop_o   (pop),
    .res_o     (res_o)
  );

endmodule
`default_nettype wire
